>>> sv/emboss_lighting_filter_core_macros.svh
// Assertion macros shared by the checker of the emboss core.
// Needs clk and arst_n visible at the point of use.
`ifndef EMBOSS_LIGHTING_FILTER_CORE_MACROS_SVH
`define EMBOSS_LIGHTING_FILTER_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define ELF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal must stay high on the edge after the trigger
`define ELF_ASSERT_HOLD(lbl, trig, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (sig)) else $error(msg);

`endif

>>> sv/elf_pkg.sv
// Package of the emboss core: payload structs, state enums, constants.
// No dependencies.
`default_nettype none
package elf_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int FRAC_BITS = 24;
	localparam int DOT_W     = 45;
	localparam int HI_W      = DOT_W - FRAC_BITS;
	localparam int PHI_W     = 32 + HI_W;
	localparam int PLO_W     = 32 + FRAC_BITS;
	localparam int M_W       = PHI_W + 1;
	localparam int V_W       = M_W + 2;
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       last_in_run;
		logic       end_of_frame;
	} out_item_t;

	typedef enum logic [2:0] {
		CFG_WIDTH   = 3'd0,
		CFG_HEIGHT  = 3'd1,
		CFG_GAIN_X  = 3'd2,
		CFG_GAIN_Y  = 3'd3,
		CFG_LIGHT_Z = 3'd4,
		CFG_AMBIENT = 3'd5,
		CFG_DIFFUSE = 3'd6
	} cfg_index_t;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CALC,
		ST_EMIT
	} core_state_t;

	typedef enum logic [2:0] {
		SH_IDLE,
		SH_SOB,
		SH_MUL,
		SH_SUM,
		SH_MHI,
		SH_MLO,
		SH_ACC,
		SH_SAT
	} shd_phase_t;

	typedef struct packed {
		logic start;
		logic narrow;
		logic second;
	} shd_req_t;

	// [column left/mid/right][row top/mid/bottom]
	typedef logic [2:0][2:0][7:0] win_t;

endpackage
`default_nettype wire

>>> sv/elf_shade.sv
// Shading unit: Sobel sums, Lambert dot product and saturation, one step a cycle.
// Depends on elf_pkg.
`default_nettype none
module elf_shade (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire elf_pkg::shd_req_t   req,
	input  wire elf_pkg::win_t       win,
	input  wire logic signed [31:0]  gain_x,
	input  wire logic signed [31:0]  gain_y,
	input  wire logic signed [31:0]  light_z,
	input  wire logic signed [31:0]  ambient_level,
	input  wire logic signed [31:0]  diffuse_gain,
	output logic                     done,
	output logic [7:0]               pixel
);

	elf_pkg::shd_phase_t phase_q, phase_n;

	logic narrow_q;
	logic signed [10:0] sx_s1, sy_s1;
	logic signed [42:0] px_s2, py_s2;
	logic [31:0] ua_s3;
	logic [elf_pkg::DOT_W-1:0] ub_s3;
	logic neg_s3;
	logic [elf_pkg::PHI_W-1:0] phi_s4;
	logic [elf_pkg::PLO_W-1:0] plo_s5;
	logic signed [elf_pkg::V_W-1:0] v_s6;

	logic [2:0][7:0] lc, mc, rc;
	logic signed [10:0] sx_n, sy_n;
	logic signed [elf_pkg::DOT_W-1:0] dot, bsel;
	logic [elf_pkg::M_W-1:0] m;
	logic signed [elf_pkg::V_W-1:0] sm;
	logic [elf_pkg::FRAC_BITS:0] lowv;
	logic [elf_pkg::FRAC_BITS+8:0] scaled;

	always_comb begin
		lc = req.second ? win[1] : win[0];
		mc = req.second ? win[2] : win[1];
		rc = win[2];
		sx_n = (11'(rc[0]) + (11'(rc[1]) << 1) + 11'(rc[2]))
			- (11'(lc[0]) + (11'(lc[1]) << 1) + 11'(lc[2]));
		sy_n = (11'(lc[2]) + (11'(mc[2]) << 1) + 11'(rc[2]))
			- (11'(lc[0]) + (11'(mc[0]) << 1) + 11'(rc[0]));
		dot = elf_pkg::DOT_W'(px_s2) + elf_pkg::DOT_W'(py_s2)
			+ elf_pkg::DOT_W'(light_z >>> 1);
		if (narrow_q) begin
			bsel = elf_pkg::DOT_W'(light_z);
		end else begin
			bsel = dot[elf_pkg::DOT_W-1] ? '0 : dot;
		end
		m = elf_pkg::M_W'(phi_s4) + elf_pkg::M_W'(plo_s5 >> elf_pkg::FRAC_BITS);
		sm = $signed({2'b00, m});
		lowv = v_s6[elf_pkg::FRAC_BITS:0];
		scaled = {lowv, 8'd0} - {8'd0, lowv};
	end

	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			elf_pkg::SH_IDLE: if (req.start) phase_n = elf_pkg::SH_SOB;
			elf_pkg::SH_SOB:  phase_n = elf_pkg::SH_MUL;
			elf_pkg::SH_MUL:  phase_n = elf_pkg::SH_SUM;
			elf_pkg::SH_SUM:  phase_n = elf_pkg::SH_MHI;
			elf_pkg::SH_MHI:  phase_n = elf_pkg::SH_MLO;
			elf_pkg::SH_MLO:  phase_n = elf_pkg::SH_ACC;
			elf_pkg::SH_ACC:  phase_n = elf_pkg::SH_SAT;
			elf_pkg::SH_SAT:  phase_n = elf_pkg::SH_IDLE;
			default:          phase_n = elf_pkg::SH_IDLE;
		endcase
	end

	always_comb begin
		done = (phase_q == elf_pkg::SH_SAT);
		if (v_s6[elf_pkg::V_W-1]) begin
			pixel = 8'd0;
		end else if (v_s6[elf_pkg::V_W-2:0] > (elf_pkg::V_W-1)'(elf_pkg::ONE_Q)) begin
			pixel = 8'd255;
		end else begin
			pixel = scaled[elf_pkg::FRAC_BITS+7:elf_pkg::FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= elf_pkg::SH_IDLE;
		end else begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == elf_pkg::SH_IDLE && req.start) begin
			narrow_q <= req.narrow;
		end
		if (phase_q == elf_pkg::SH_SOB) begin
			sx_s1 <= sx_n;
			sy_s1 <= sy_n;
		end
		if (phase_q == elf_pkg::SH_MUL) begin
			px_s2 <= 43'(gain_x) * 43'(sx_s1);
			py_s2 <= 43'(gain_y) * 43'(sy_s1);
		end
		if (phase_q == elf_pkg::SH_SUM) begin
			ua_s3  <= diffuse_gain[31] ? 32'(-diffuse_gain) : 32'(diffuse_gain);
			ub_s3  <= bsel[elf_pkg::DOT_W-1] ? elf_pkg::DOT_W'(-bsel) : elf_pkg::DOT_W'(bsel);
			neg_s3 <= diffuse_gain[31] ^ bsel[elf_pkg::DOT_W-1];
		end
		if (phase_q == elf_pkg::SH_MHI) begin
			phi_s4 <= elf_pkg::PHI_W'(ua_s3)
				* elf_pkg::PHI_W'(ub_s3[elf_pkg::DOT_W-1:elf_pkg::FRAC_BITS]);
		end
		if (phase_q == elf_pkg::SH_MLO) begin
			plo_s5 <= elf_pkg::PLO_W'(ua_s3)
				* elf_pkg::PLO_W'(ub_s3[elf_pkg::FRAC_BITS-1:0]);
		end
		if (phase_q == elf_pkg::SH_ACC) begin
			v_s6 <= elf_pkg::V_W'(ambient_level) + (neg_s3 ? -sm : sm);
		end
	end

endmodule
`default_nettype wire

>>> sv/emboss_lighting_filter_core.sv
// Emboss core: line buffers in two 1-port-read synchronous memories, 3x3 window.
// Items without results go through the read state only; each result adds the
// 7-step shading unit plus output register to the item. One item in flight at a time.
// Reset clears counters, window and control; line buffers are not cleared.
// Depends on elf_pkg and elf_shade.
`default_nettype none
module emboss_lighting_filter_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire elf_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output elf_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic signed [31:0] gain_x_q, gain_y_q, light_z_q, ambient_q, diffuse_q;

	elf_pkg::core_state_t state_q, state_n;
	elf_pkg::in_item_t item_q;
	elf_pkg::out_item_t out_q;
	elf_pkg::win_t win_q;
	logic [10:0] column_q;
	logic [15:0] row_q;
	logic sel_second_q, second_pend_q;

	logic [7:0] above_mem_q [elf_pkg::MAX_WIDTH];
	logic [7:0] center_mem_q [elf_pkg::MAX_WIDTH];
	logic [7:0] abv_rd_q, cen_rd_q;

	logic [10:0] w_eff, wm1, c_full;
	logic [elf_pkg::ADDR_W-1:0] c;
	logic [15:0] h_eff;
	logic narrow, acc, go, r0, at_end, has_first, has_res, emit_done;
	logic mem_rd, wr_abv, wr_cen, start;
	logic [7:0] above, below;
	elf_pkg::shd_req_t req;
	logic shd_done;
	logic [7:0] shd_pixel;

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = 11'd1;
		end else if (width_q > 11'(elf_pkg::MAX_WIDTH)) begin
			w_eff = 11'(elf_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		wm1 = w_eff - 11'd1;
		c_full = (column_q > wm1) ? wm1 : column_q;
		c = c_full[elf_pkg::ADDR_W-1:0];
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
		narrow = (w_eff < 11'd4) || (h_eff < 16'd4);
		acc = in_valid && !in_stall;
		go = acc && ((in_item.command != elf_pkg::CMD_DRAIN && row_q < h_eff)
			|| (in_item.command == elf_pkg::CMD_DRAIN && row_q >= h_eff));
		r0 = (row_q == 16'd0);
		at_end = (c_full == wm1);
		has_first = (c_full != 11'd0);
		has_res = !r0 && (has_first || at_end);
		emit_done = !out_stall;
		above = (row_q == 16'd1) ? cen_rd_q : abv_rd_q;
		below = (item_q.command == elf_pkg::CMD_DRAIN) ? cen_rd_q : item_q.pixel_in;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			elf_pkg::ST_IDLE: if (go) state_n = elf_pkg::ST_RD;
			elf_pkg::ST_RD:   state_n = has_res ? elf_pkg::ST_CALC : elf_pkg::ST_IDLE;
			elf_pkg::ST_CALC: if (shd_done) state_n = elf_pkg::ST_EMIT;
			elf_pkg::ST_EMIT: begin
				if (emit_done) begin
					state_n = second_pend_q ? elf_pkg::ST_CALC : elf_pkg::ST_IDLE;
				end
			end
			default: state_n = elf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != elf_pkg::ST_IDLE);
		out_valid = (state_q == elf_pkg::ST_EMIT);
		out_item = out_q;
		mem_rd = (state_q == elf_pkg::ST_IDLE) && go;
		wr_cen = (state_q == elf_pkg::ST_RD) && (r0 || item_q.command != elf_pkg::CMD_DRAIN);
		wr_abv = (state_q == elf_pkg::ST_RD) && !r0 && item_q.command != elf_pkg::CMD_DRAIN;
		start = ((state_q == elf_pkg::ST_RD) && has_res)
			|| ((state_q == elf_pkg::ST_EMIT) && emit_done && second_pend_q);
		req.start = start;
		req.narrow = narrow;
		req.second = sel_second_q;
	end

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			abv_rd_q <= above_mem_q[c];
			cen_rd_q <= center_mem_q[c];
		end
		if (wr_abv) begin
			above_mem_q[c] <= cen_rd_q;
		end
		if (wr_cen) begin
			center_mem_q[c] <= item_q.pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd1024;
			height_q  <= 16'd768;
			gain_x_q  <= '0;
			gain_y_q  <= '0;
			light_z_q <= 32'sd16777216;
			ambient_q <= '0;
			diffuse_q <= 32'sd16777216;
		end else if (cfg_we) begin
			unique case (elf_pkg::cfg_index_t'(cfg_index))
				elf_pkg::CFG_WIDTH:   width_q   <= cfg_data[10:0];
				elf_pkg::CFG_HEIGHT:  height_q  <= cfg_data[15:0];
				elf_pkg::CFG_GAIN_X:  gain_x_q  <= $signed(cfg_data);
				elf_pkg::CFG_GAIN_Y:  gain_y_q  <= $signed(cfg_data);
				elf_pkg::CFG_LIGHT_Z: light_z_q <= $signed(cfg_data);
				elf_pkg::CFG_AMBIENT: ambient_q <= $signed(cfg_data);
				elf_pkg::CFG_DIFFUSE: diffuse_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			item_q <= in_item;
		end
		if (state_q == elf_pkg::ST_CALC && shd_done) begin
			out_q.pixel_out    <= shd_pixel;
			out_q.last_in_run  <= sel_second_q || !second_pend_q;
			out_q.end_of_frame <= sel_second_q && item_q.command == elf_pkg::CMD_DRAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= elf_pkg::ST_IDLE;
			win_q         <= '0;
			column_q      <= '0;
			row_q         <= '0;
			sel_second_q  <= 1'b0;
			second_pend_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == elf_pkg::ST_RD) begin
				if (!r0) begin
					if (c_full == 11'd0) begin
						win_q <= {3{below, cen_rd_q, above}};
					end else begin
						win_q <= {{below, cen_rd_q, above}, win_q[2], win_q[1]};
					end
				end
				sel_second_q  <= !has_first;
				second_pend_q <= has_first && at_end;
				if (at_end) begin
					column_q <= '0;
					row_q <= (item_q.command == elf_pkg::CMD_DRAIN) ? 16'd0 : row_q + 16'd1;
				end else begin
					column_q <= c_full + 11'd1;
				end
			end
			if (state_q == elf_pkg::ST_EMIT && emit_done && second_pend_q) begin
				sel_second_q  <= 1'b1;
				second_pend_q <= 1'b0;
			end
		end
	end

	elf_shade u_shade (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.win           (win_q),
		.gain_x        (gain_x_q),
		.gain_y        (gain_y_q),
		.light_z       (light_z_q),
		.ambient_level (ambient_q),
		.diffuse_gain  (diffuse_q),
		.done          (shd_done),
		.pixel         (shd_pixel)
	);

endmodule
`default_nettype wire

>>> sv/elf_checker.sv
// Port checker for the emboss core, bound to the top level.
// Depends on elf_pkg and the assertion macro header.
`default_nettype none
`include "emboss_lighting_filter_core_macros.svh"
module elf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire elf_pkg::out_item_t out_item
);

	`ELF_ASSERT_HOLD(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`ELF_ASSERT(a_no_take_busy, out_valid |-> in_stall, "input taken while result pending")
	`ELF_ASSERT(a_eof_last, (out_valid && out_item.end_of_frame) |-> out_item.last_in_run, "frame end not last of run")
	`ELF_ASSERT(a_gap_after, (out_valid && !out_stall && !out_item.last_in_run) |=> !out_valid, "second result too early")

endmodule

bind emboss_lighting_filter_core elf_checker u_elf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire

>>> test/tb_emboss_lighting_filter_core.sv
// Self-checking testbench for the emboss core: streams raster frames through the
// valid/stall ports and compares every output pixel with a built-in predictor.
// Depends on elf_pkg and emboss_lighting_filter_core.
`timescale 1ns / 1ps
module tb_emboss_lighting_filter_core;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 24;

	class emboss_scoreboard;
		int        above_line[elf_pkg::MAX_WIDTH];
		int        center_line[elf_pkg::MAX_WIDTH];
		int        win[3][3];
		int unsigned col, row;
		int unsigned width_reg, height_reg;
		longint    gx, gy, lz, amb, dif;
		elf_pkg::out_item_t pending[$];
		int        errors, checked;

		function new();
			col = 0; row = 0;
			width_reg = 1024; height_reg = 768;
			gx = 0; gy = 0; lz = 16777216; amb = 0; dif = 16777216;
			foreach (win[i, j]) win[i][j] = 0;
		endfunction

		function void write_reg(elf_pkg::cfg_index_t idx, logic [31:0] d);
			case (idx)
				elf_pkg::CFG_WIDTH:   width_reg = d[10:0];
				elf_pkg::CFG_HEIGHT:  height_reg = d[15:0];
				elf_pkg::CFG_GAIN_X:  gx = longint'($signed(d));
				elf_pkg::CFG_GAIN_Y:  gy = longint'($signed(d));
				elf_pkg::CFG_LIGHT_Z: lz = longint'($signed(d));
				elf_pkg::CFG_AMBIENT: amb = longint'($signed(d));
				elf_pkg::CFG_DIFFUSE: dif = longint'($signed(d));
				default: ;
			endcase
		endfunction

		function longint scale_q(longint a, longint b);
			bit neg;
			longint unsigned ua, ub, m, mask;
			neg = (a < 0) != (b < 0);
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			mask = (64'd1 << elf_pkg::FRAC_BITS) - 1;
			m = ua * (ub >> elf_pkg::FRAC_BITS) + ((ua * (ub & mask)) >> elf_pkg::FRAC_BITS);
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function logic [7:0] to_pixel(longint v);
			longint prod;
			if (v < 0) return 8'd0;
			if (v > (longint'(1) << elf_pkg::FRAC_BITS)) return 8'd255;
			prod = (v * 255) >>> elf_pkg::FRAC_BITS;
			return prod[7:0];
		endfunction

		function logic [7:0] lit(int l, int m, int r);
			longint sx, sy, dot;
			sx = (win[r][0] + 2 * win[r][1] + win[r][2]) - (win[l][0] + 2 * win[l][1] + win[l][2]);
			sy = (win[l][2] + 2 * win[m][2] + win[r][2]) - (win[l][0] + 2 * win[m][0] + win[r][0]);
			dot = gx * sx + gy * sy + (lz >>> 1);
			if (dot < 0) dot = 0;
			return to_pixel(amb + scale_q(dif, dot));
		endfunction

		function void note_input(elf_pkg::in_item_t it);
			int unsigned w, h, c, r;
			bit drain, tiny;
			int p, above, center, below;
			elf_pkg::out_item_t res;
			w = (width_reg == 0) ? 1 : width_reg;
			if (w > elf_pkg::MAX_WIDTH) w = elf_pkg::MAX_WIDTH;
			h = (height_reg == 0) ? 1 : height_reg;
			drain = (it.command == elf_pkg::CMD_DRAIN);
			p = it.pixel_in;
			r = row;
			c = (col > w - 1) ? w - 1 : col;
			tiny = (w < 4) || (h < 4);
			if (!drain && r >= h) return;
			if (drain && r < h) return;
			if (r == 0) begin
				center_line[c] = p;
				if (c == w - 1) begin
					col = 0; row = 1;
				end else col = c + 1;
				return;
			end
			center = center_line[c];
			above = (r == 1) ? center : above_line[c];
			below = drain ? center : p;
			if (!drain) begin
				above_line[c] = center;
				center_line[c] = p;
			end
			if (c == 0) begin
				for (int i = 0; i < 3; i++) begin
					win[i][0] = above; win[i][1] = center; win[i][2] = below;
				end
			end else begin
				win[0] = win[1];
				win[1] = win[2];
				win[2][0] = above; win[2][1] = center; win[2][2] = below;
			end
			if (c >= 1) begin
				res.pixel_out = tiny ? to_pixel(amb + scale_q(dif, lz)) : lit(0, 1, 2);
				res.last_in_run = (c != w - 1);
				res.end_of_frame = 1'b0;
				pending.push_back(res);
			end
			if (c == w - 1) begin
				res.pixel_out = tiny ? to_pixel(amb + scale_q(dif, lz)) : lit(1, 2, 2);
				res.last_in_run = 1'b1;
				res.end_of_frame = drain;
				pending.push_back(res);
				col = 0;
				row = drain ? 0 : r + 1;
			end else col = c + 1;
		endfunction

		function void check(elf_pkg::out_item_t got);
			elf_pkg::out_item_t exp_item;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			checked++;
			if (got.pixel_out !== exp_item.pixel_out) begin
				$display("%0t: pixel_out expected %0d actual %0d", $time,
					exp_item.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.last_in_run !== exp_item.last_in_run) begin
				$display("%0t: last_in_run expected %0b actual %0b", $time,
					exp_item.last_in_run, got.last_in_run);
				errors++;
			end
			if (got.end_of_frame !== exp_item.end_of_frame) begin
				$display("%0t: end_of_frame expected %0b actual %0b", $time,
					exp_item.end_of_frame, got.end_of_frame);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	elf_pkg::in_item_t  in_item;
	elf_pkg::out_item_t out_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	emboss_scoreboard shading = new();
	bit  no_idle;
	int  pixels_sent, frames_done, cycles;

	emboss_lighting_filter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_emboss_lighting_filter_core NOT OK");
			$finish;
		end
	end

	always @(negedge clk) out_stall = !no_idle && ($urandom_range(99) < 22);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) shading.check(out_item);
	end

	task automatic transfer(logic cmd, logic [7:0] p);
		elf_pkg::in_item_t it;
		it.command = cmd;
		it.pixel_in = p;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 22) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		shading.note_input(it);
		if (cmd != elf_pkg::CMD_DRAIN) pixels_sent++;
	endtask

	// hold the sender until every expected pixel is out and the core has settled
	task automatic drain_out();
		@(negedge clk);
		in_valid = 1'b0;
		while (shading.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(elf_pkg::cfg_index_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		shading.write_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_light(logic [31:0] gxv, gyv, lzv, ambv, difv);
		cfg_write(elf_pkg::CFG_GAIN_X, gxv);
		cfg_write(elf_pkg::CFG_GAIN_Y, gyv);
		cfg_write(elf_pkg::CFG_LIGHT_Z, lzv);
		cfg_write(elf_pkg::CFG_AMBIENT, ambv);
		cfg_write(elf_pkg::CFG_DIFFUSE, difv);
	endtask

	function automatic logic [31:0] pick_q(int range_bits, bit allow_neg);
		int unsigned mag;
		mag = $urandom_range((1 << range_bits) - 1);
		return (allow_neg && $urandom_range(1)) ? -mag : mag;
	endfunction

	task automatic random_light();
		case ($urandom_range(9))
			0: set_light($urandom, $urandom, $urandom, $urandom, $urandom);
			1: set_light(32'h7fffffff, 32'h80000000, pick_q(25, 1), 32'h80000000, 32'h7fffffff);
			default: set_light(pick_q(17, 1), pick_q(17, 1), pick_q(25, 1),
				pick_q(23, 1), pick_q(25, $urandom_range(3) == 0));
		endcase
	endtask

	// w is the width the core will act on, the register may hold an aliased value
	task automatic run_frame(int w, int h, int texture);
		logic [7:0] p;
		int base;
		base = $urandom_range(255);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if ($urandom_range(99) < 3) transfer(elf_pkg::CMD_DRAIN, 8'($urandom));
				case (texture)
					0: p = 8'($urandom);
					1: p = 8'(base + c * 9 + r * 5);
					default: p = ($urandom_range(9) == 0) ? {8{$urandom_range(1) == 1}} : 8'(base);
				endcase
				transfer(elf_pkg::CMD_PIXEL, p);
			end
		end
		if ($urandom_range(3) == 0) transfer(elf_pkg::CMD_PIXEL, 8'($urandom));
		for (int c = 0; c < w; c++) transfer(elf_pkg::CMD_DRAIN, 8'($urandom));
		frames_done++;
	endtask

	task automatic geometry(int unsigned w, int unsigned h);
		drain_out();
		cfg_write(elf_pkg::CFG_WIDTH, w);
		cfg_write(elf_pkg::CFG_HEIGHT, h);
	endtask

	initial begin
		int w, h, start_px;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = elf_pkg::CFG_WIDTH;
		cfg_data = '0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		geometry(4, 4);
		set_light(32'h00400000, 32'hffc00000, 32'h01000000, 32'h0, 32'h01000000);
		for (int i = 0; i < 16; i++) begin
			if (i == 6) transfer(elf_pkg::CMD_DRAIN, 8'hff);
			transfer(elf_pkg::CMD_PIXEL, (i % 3 == 0) ? 8'hff : ((i % 3 == 1) ? 8'h00 : 8'h80));
		end
		transfer(elf_pkg::CMD_PIXEL, 8'h5a);
		for (int i = 0; i < 4; i++) transfer(elf_pkg::CMD_DRAIN, 8'h00);

		geometry(5, 4);
		set_light(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
		run_frame(5, 4, 0);
		drain_out();
		set_light(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		run_frame(5, 4, 1);
		geometry(0, 3);
		random_light();
		run_frame(1, 3, 0);
		geometry(5, 0);
		run_frame(5, 1, 0);

		// frame started tall, cut short once the core has gone quiet
		geometry(5, 65535);
		for (int i = 0; i < 15; i++) transfer(elf_pkg::CMD_PIXEL, 8'($urandom));
		drain_out();
		cfg_write(elf_pkg::CFG_HEIGHT, 2);
		for (int i = 0; i < 5; i++) transfer(elf_pkg::CMD_DRAIN, 8'h00);

		start_px = pixels_sent;
		while (pixels_sent - start_px < 520) begin
			no_idle = (pixels_sent - start_px > 200) && (pixels_sent - start_px < 320);
			w = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			h = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 7);
			if ($urandom_range(1) || shading.width_reg != w) begin
				geometry(w, h);
				random_light();
			end else if (shading.height_reg != h) begin
				geometry(w, h);
			end
			run_frame(w, h, $urandom_range(2));
		end
		no_idle = 1'b0;

		drain_out();
		repeat (SETTLE) @(posedge clk);
		if (shading.pending.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, shading.pending.size());
			shading.errors++;
		end
		$display("Streamed %0d frames, %0d pixels; %0d output pixels compared.",
			frames_done, pixels_sent, shading.checked);
		if (shading.errors == 0) begin
			$display("tb_emboss_lighting_filter_core OK");
		end else begin
			$display("tb_emboss_lighting_filter_core NOT OK");
		end
		$finish;
	end
endmodule

>>> emboss_lighting_filter_core.f
+incdir+sv
sv/elf_pkg.sv
sv/elf_shade.sv
sv/emboss_lighting_filter_core.sv
sv/elf_checker.sv
test/tb_emboss_lighting_filter_core.sv
